[rtl/core/pos_pkg.sv]
// Shared constants, widths and the CORDIC arctangent table for the periodic occupancy model.
// No dependencies; used by periodic_occupancy_spectral_model.
package pos_pkg;

    localparam int NUM_PERIODS  = 8;
    localparam int CORDIC_STEPS = 16;
    localparam int MAX_STEPS    = 24;
    localparam int STEPS        = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;

    localparam int IDX_W  = (NUM_PERIODS > 1) ? $clog2(NUM_PERIODS) : 1;
    localparam int STEP_W = 5;
    localparam int PER_W  = 12;
    localparam int ACC_W  = 48;
    localparam int MEAN_W = 24;
    localparam int CNT_W  = 32;
    localparam int AMP_W  = 20;
    localparam int PH_W   = 32;
    localparam int XY_W   = 52;
    localparam int Z_W    = 34;
    localparam int DQ_W   = 52;
    localparam int DR_W   = 33;
    localparam int MUL_W  = 34;
    localparam int PROD_W = 68;
    localparam int EST_W  = 40;
    localparam int DCNT_W = 6;

    localparam logic [MUL_W-1:0] GAIN_Q30 = 34'd652032874;
    localparam logic [AMP_W-1:0] GAIN_Q20 = 20'd636751;
    localparam logic [AMP_W-1:0] AMP_MAX  = 20'hFFFFF;
    localparam logic [EST_W-1:0] HALF_Q24 = 40'h0000800000;
    localparam logic [MEAN_W-1:0] MEAN_RESET = 24'h800000;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic CFG_ORDER = 1'b0;
    localparam logic CFG_THR   = 1'b1;

    typedef logic [4:0] t_state;

    // Arctangent of 2^-k in turns, Q0.32.
    function automatic logic [31:0] atan_turns(input logic [STEP_W-1:0] k);
        logic [31:0] v;
        case (k)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/periodic_occupancy_spectral_model.sv]
// Periodic occupancy model: running mean plus per-period complex accumulators, with query.
// Depends on pos_pkg for widths, constants and the arctangent table.
//
// An add beat keeps the input stalled until every accumulator is updated. A query keeps it
// stalled through the magnitude pass, the ranking and the CORDIC of each used component,
// until its result beat is loaded, which waits for any stalled output beat.
// Throughput: one beat at a time; the shared bit-serial divider and the CORDIC unit set it.
// Reset (synchronous, active low) restores mean one half, count zero, accumulators zero,
// order two and threshold zero; the block is ready in the first cycle after reset.
module periodic_occupancy_spectral_model (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [31:0] i_time_s,
    input  logic [15:0] i_probability,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_occupied,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int NP   = pos_pkg::NUM_PERIODS;
    localparam int IW   = pos_pkg::IDX_W;
    localparam int XW   = pos_pkg::XY_W;
    localparam int ZW   = pos_pkg::Z_W;
    localparam int QW   = pos_pkg::DQ_W;
    localparam int RW   = pos_pkg::DR_W;
    localparam int MW   = pos_pkg::MUL_W;
    localparam int PW   = pos_pkg::PROD_W;
    localparam int AW   = pos_pkg::ACC_W;
    localparam int EW   = pos_pkg::EST_W;
    localparam int CW   = pos_pkg::DCNT_W;

    // Sequencer states.
    localparam pos_pkg::t_state S_IDLE     = 5'd0;
    localparam pos_pkg::t_state S_MEAN_MUL = 5'd1;
    localparam pos_pkg::t_state S_MEAN_LD  = 5'd2;
    localparam pos_pkg::t_state S_DIV      = 5'd3;
    localparam pos_pkg::t_state S_MEAN_WR  = 5'd4;
    localparam pos_pkg::t_state S_MOD_LD   = 5'd5;
    localparam pos_pkg::t_state S_FRAC_LD  = 5'd6;
    localparam pos_pkg::t_state S_ROT_LD   = 5'd7;
    localparam pos_pkg::t_state S_CORDIC   = 5'd8;
    localparam pos_pkg::t_state S_ACC_RE   = 5'd9;
    localparam pos_pkg::t_state S_ACC_IM   = 5'd10;
    localparam pos_pkg::t_state S_ACC_WR   = 5'd11;
    localparam pos_pkg::t_state S_Q_VEC_LD = 5'd12;
    localparam pos_pkg::t_state S_Q_MAG_LD = 5'd13;
    localparam pos_pkg::t_state S_Q_RG_MUL = 5'd14;
    localparam pos_pkg::t_state S_Q_RG_LD  = 5'd15;
    localparam pos_pkg::t_state S_Q_D2     = 5'd16;
    localparam pos_pkg::t_state S_Q_QG_MUL = 5'd17;
    localparam pos_pkg::t_state S_Q_AMP    = 5'd18;
    localparam pos_pkg::t_state S_RANK     = 5'd19;
    localparam pos_pkg::t_state S_RANK_END = 5'd20;
    localparam pos_pkg::t_state S_EST_MUL  = 5'd21;
    localparam pos_pkg::t_state S_EST_ADD  = 5'd22;
    localparam pos_pkg::t_state S_NEXT_I   = 5'd23;
    localparam pos_pkg::t_state S_OUT      = 5'd24;

    localparam logic [IW-1:0] LAST_I = IW'(NP - 1);

    // Period lengths in seconds, worked out at elaboration.
    logic [pos_pkg::PER_W-1:0] w_per [NP];
    genvar g;
    generate
        for (g = 0; g < NP; g++) begin : g_per
            localparam int PER_RAW = (NP * 100) / (g + 1);
            localparam int PER     = (PER_RAW < 1) ? 1 : PER_RAW;
            assign w_per[g] = pos_pkg::PER_W'(PER);
        end
    endgenerate

    // Architectural state.
    logic [3:0]                  r_order;
    logic [15:0]                 r_thr;
    logic [pos_pkg::MEAN_W-1:0]  r_mean;
    logic [pos_pkg::CNT_W-1:0]   r_count;
    logic signed [AW-1:0]        r_re [NP];
    logic signed [AW-1:0]        r_im [NP];

    // Sequencer and working registers.
    pos_pkg::t_state             r_state;
    pos_pkg::t_state             r_ret;
    logic                        r_query;
    logic [31:0]                 r_time;
    logic [15:0]                 r_prob;
    logic [IW-1:0]               r_i;
    logic [IW-1:0]               r_j;
    logic [IW-1:0]               r_rank;
    logic signed [24:0]          r_diff;
    logic signed [EW-1:0]        r_est;
    logic [pos_pkg::AMP_W-1:0]   r_amp [NP];
    logic [pos_pkg::PH_W-1:0]    r_ph  [NP];
    logic [24:0]                 r_q;
    logic [pos_pkg::AMP_W-1:0]   r_d2;
    logic                        r_out_valid;
    logic                        r_occ;

    // Shared bit-serial divider: remainder, quotient/dividend shift register, divisor.
    logic [RW-1:0]               r_rem;
    logic [QW-1:0]               r_quo;
    logic [RW-1:0]               r_div;
    logic [CW-1:0]               r_cnt;

    // Shared CORDIC unit.
    logic signed [XW-1:0]        r_x;
    logic signed [XW-1:0]        r_y;
    logic signed [ZW-1:0]        r_z;
    logic [pos_pkg::STEP_W-1:0]  r_k;
    logic                        r_vec;
    logic                        r_neg;

    // Shared multiplier, registered.
    logic signed [MW-1:0]        w_ma;
    logic signed [MW-1:0]        w_mb;
    logic signed [PW-1:0]        r_prod;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_occupied  = r_occ;

    // Divider step.
    logic [RW:0]   w_dshift;
    logic [RW+1:0] w_dtrial;
    assign w_dshift = {r_rem, r_quo[QW-1]};
    assign w_dtrial = {1'b0, w_dshift} - {2'b00, r_div};

    // CORDIC step: one micro-rotation per cycle.
    logic signed [XW-1:0] w_xs;
    logic signed [XW-1:0] w_ys;
    logic signed [ZW-1:0] w_at;
    logic                 w_pos;
    assign w_xs  = r_x >>> r_k;
    assign w_ys  = r_y >>> r_k;
    assign w_at  = $signed({2'b00, pos_pkg::atan_turns(r_k)});
    // Rotation follows the sign of the residual angle; vectoring drives y toward zero.
    assign w_pos = r_vec ? !(!r_y[XW-1] && (r_y != '0)) : !r_z[ZW-1];

    // Cosine and sine after rotation, with the half-turn fold undone.
    logic signed [MW-1:0] w_c;
    logic signed [MW-1:0] w_s;
    assign w_c = r_neg ? -r_x[MW-1:0] : r_x[MW-1:0];
    assign w_s = r_neg ? -r_y[MW-1:0] : r_y[MW-1:0];

    // Multiplier operand selection.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_MEAN_MUL: begin
                w_ma = $signed(MW'(r_mean));
                w_mb = $signed(MW'(r_count));
            end
            S_ACC_RE: begin
                w_ma = MW'(r_diff);
                w_mb = w_c;
            end
            S_ACC_IM: begin
                w_ma = MW'(r_diff);
                w_mb = w_s;
            end
            S_Q_RG_MUL: begin
                w_ma = $signed(MW'(r_rem));
                w_mb = $signed(MW'(pos_pkg::GAIN_Q20));
            end
            S_Q_QG_MUL: begin
                w_ma = $signed(MW'(r_q));
                w_mb = $signed(MW'(pos_pkg::GAIN_Q20));
            end
            S_EST_MUL: begin
                w_ma = $signed(MW'(r_amp[r_i]));
                w_mb = w_c;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // Rounded mean numerator: mean*n + p*2^8 + (n+1)/2.
    logic [56:0] w_dsum;
    logic [32:0] w_n1;
    assign w_n1   = 33'(r_count) + 33'd1;
    assign w_dsum = {1'b0, r_prod[55:0]} + 57'({r_prob, 8'h00}) + 57'(w_n1 >> 1);

    // Rotation angle with the fold into the right half plane.
    logic [31:0] w_ang;
    logic [31:0] w_ang_sum;
    logic        w_fold;
    assign w_ang     = r_query ? (r_quo[31:0] - r_ph[r_i]) : r_quo[31:0];
    assign w_ang_sum = w_ang + 32'h40000000;
    assign w_fold    = w_ang_sum[31];

    // Accumulator update with rounding and saturation.
    logic signed [PW-1:0] w_aterm_full;
    logic signed [AW:0]   w_re_sum;
    logic signed [AW:0]   w_im_sum;
    logic signed [AW-1:0] w_re_sat;
    logic signed [AW-1:0] w_im_sat;
    assign w_aterm_full = (r_prod + (PW'(1) <<< 37)) >>> 38;

    function automatic logic signed [AW-1:0] sat_acc(input logic signed [AW:0] v);
        logic signed [AW-1:0] res;
        if (!v[AW] && v[AW-1]) begin
            res = {1'b0, {(AW-1){1'b1}}};
        end else if (v[AW] && !v[AW-1]) begin
            res = {1'b1, {(AW-1){1'b0}}};
        end else begin
            res = v[AW-1:0];
        end
        return res;
    endfunction

    assign w_re_sum = {r_re[r_i][AW-1], r_re[r_i]} + w_aterm_full[AW:0];
    assign w_im_sum = {r_im[r_i][AW-1], r_im[r_i]} + w_aterm_full[AW:0];
    assign w_re_sat = sat_acc(w_re_sum);
    assign w_im_sat = sat_acc(w_im_sum);

    // Amplitude from the two partial quotients.
    logic [44:0] w_asum;
    logic [24:0] w_a25;
    logic [pos_pkg::AMP_W-1:0] w_asat;
    logic [pos_pkg::AMP_W-1:0] w_amp;
    assign w_asum = 45'(r_prod[43:0]) + 45'(r_d2) + 45'h80000;
    assign w_a25  = w_asum[44:20];
    assign w_asat = (w_a25 > 25'(pos_pkg::AMP_MAX)) ? pos_pkg::AMP_MAX : w_a25[19:0];
    assign w_amp  = (w_asat < 20'(r_thr)) ? '0 : w_asat;

    // Component term of the estimate, rounded to Q0.24.
    logic signed [PW-1:0] w_eterm;
    assign w_eterm = (r_prod + (PW'(1) <<< 20)) >>> 21;

    // Vectoring start values: fold the left half plane over by a half turn.
    logic signed [XW-1:0] w_vx;
    logic signed [XW-1:0] w_vy;
    assign w_vx = XW'(r_re[r_i]);
    assign w_vy = XW'(r_im[r_i]);

    // Rank test: a component ahead of the current one.
    logic w_ahead;
    assign w_ahead = (r_amp[r_j] > r_amp[r_i]) ||
                     ((r_amp[r_j] == r_amp[r_i]) && (r_j < r_i));

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_order     <= 4'd2;
            r_thr       <= '0;
            r_mean      <= pos_pkg::MEAN_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_cnt       <= '0;
            r_k         <= '0;
            for (int n = 0; n < NP; n++) begin
                r_re[n] <= '0;
                r_im[n] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pos_pkg::CFG_ORDER: r_order <= i_cfg_data[3:0];
                    pos_pkg::CFG_THR:   r_thr   <= i_cfg_data;
                    default: ;
                endcase
            end

            // In S_OUT the output register is reloaded below instead of cleared here.
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_time  <= i_time_s;
                        r_prob  <= i_probability;
                        r_query <= (i_req_type == pos_pkg::REQ_QUERY);
                        r_i     <= '0;
                        r_j     <= '0;
                        r_rank  <= '0;
                        r_est   <= EW'(r_mean);
                        r_state <= (i_req_type == pos_pkg::REQ_QUERY) ? S_Q_VEC_LD : S_MEAN_MUL;
                    end
                end

                S_MEAN_MUL: begin
                    r_state <= S_MEAN_LD;
                end

                S_MEAN_LD: begin
                    r_rem   <= w_dsum[56:24];
                    r_quo   <= {w_dsum[23:0], 28'h0};
                    r_div   <= w_n1;
                    r_cnt   <= CW'(24);
                    r_ret   <= S_MEAN_WR;
                    r_state <= S_DIV;
                end

                S_DIV: begin
                    if (!w_dtrial[RW+1]) begin
                        r_rem <= w_dtrial[RW-1:0];
                    end else begin
                        r_rem <= w_dshift[RW-1:0];
                    end
                    r_quo <= {r_quo[QW-2:0], !w_dtrial[RW+1]};
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= r_ret;
                    end
                end

                S_MEAN_WR: begin
                    r_mean  <= r_quo[23:0];
                    r_diff  <= $signed({1'b0, r_prob, 8'h00}) - $signed({1'b0, r_quo[23:0]});
                    if (r_count != '1) begin
                        r_count <= r_count + 32'd1;
                    end
                    r_state <= S_MOD_LD;
                end

                // Phase of the time stamp: first t mod P, then (remainder << 32) / P.
                S_MOD_LD: begin
                    r_rem   <= '0;
                    r_quo   <= {r_time, 20'h0};
                    r_div   <= RW'(w_per[r_i]);
                    r_cnt   <= CW'(32);
                    r_ret   <= S_FRAC_LD;
                    r_state <= S_DIV;
                end

                S_FRAC_LD: begin
                    r_quo   <= '0;
                    r_cnt   <= CW'(32);
                    r_ret   <= S_ROT_LD;
                    r_state <= S_DIV;
                end

                S_ROT_LD: begin
                    r_neg   <= w_fold;
                    r_z     <= ZW'($signed(w_fold ? (w_ang ^ 32'h80000000) : w_ang));
                    r_x     <= XW'($signed(pos_pkg::GAIN_Q30));
                    r_y     <= '0;
                    r_vec   <= 1'b0;
                    r_k     <= '0;
                    r_ret   <= r_query ? S_EST_MUL : S_ACC_RE;
                    r_state <= S_CORDIC;
                end

                S_CORDIC: begin
                    if (w_pos) begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_at;
                    end else begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_at;
                    end
                    if (r_k == pos_pkg::STEP_W'(pos_pkg::STEPS - 1)) begin
                        r_state <= r_ret;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end

                S_ACC_RE: begin
                    r_state <= S_ACC_IM;
                end

                S_ACC_IM: begin
                    r_re[r_i] <= w_re_sat;
                    r_state   <= S_ACC_WR;
                end

                S_ACC_WR: begin
                    r_im[r_i] <= w_im_sat;
                    if (r_i == LAST_I) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_MOD_LD;
                    end
                end

                // Query, first pass: magnitude and angle of each accumulator.
                S_Q_VEC_LD: begin
                    if (w_vx < 0) begin
                        r_x <= -w_vx;
                        r_y <= -w_vy;
                        r_z <= ZW'(34'h080000000);
                    end else begin
                        r_x <= w_vx;
                        r_y <= w_vy;
                        r_z <= '0;
                    end
                    r_vec   <= 1'b1;
                    r_k     <= '0;
                    r_ret   <= S_Q_MAG_LD;
                    r_state <= S_CORDIC;
                end

                S_Q_MAG_LD: begin
                    r_ph[r_i] <= r_z[31:0];
                    if (r_count == '0) begin
                        r_q     <= '0;
                        r_d2    <= '0;
                        r_state <= S_Q_QG_MUL;
                    end else begin
                        r_rem   <= '0;
                        r_quo   <= r_x[XW-1] ? '0 : r_x;
                        r_div   <= RW'(r_count);
                        r_cnt   <= CW'(QW);
                        r_ret   <= S_Q_RG_MUL;
                        r_state <= S_DIV;
                    end
                end

                S_Q_RG_MUL: begin
                    // Quotient is capped at 2^24; the remainder goes through the multiplier.
                    r_q     <= (r_quo > QW'(25'h1000000)) ? 25'h1000000 : r_quo[24:0];
                    r_state <= S_Q_RG_LD;
                end

                S_Q_RG_LD: begin
                    r_rem   <= '0;
                    r_quo   <= r_prod[QW-1:0];
                    r_cnt   <= CW'(QW);
                    r_ret   <= S_Q_D2;
                    r_state <= S_DIV;
                end

                S_Q_D2: begin
                    r_d2    <= r_quo[pos_pkg::AMP_W-1:0];
                    r_state <= S_Q_QG_MUL;
                end

                S_Q_QG_MUL: begin
                    r_state <= S_Q_AMP;
                end

                S_Q_AMP: begin
                    r_amp[r_i] <= w_amp;
                    if (r_i == LAST_I) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_rank  <= '0;
                        r_state <= S_RANK;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_Q_VEC_LD;
                    end
                end

                // Second pass: rank each component against all others, one compare a cycle.
                S_RANK: begin
                    if (w_ahead) begin
                        r_rank <= r_rank + 1'b1;
                    end
                    if (r_j == LAST_I) begin
                        r_state <= S_RANK_END;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end

                S_RANK_END: begin
                    if ((8'(r_rank) < 8'(r_order)) && (r_amp[r_i] != '0)) begin
                        r_state <= S_MOD_LD;
                    end else begin
                        r_state <= S_NEXT_I;
                    end
                end

                S_EST_MUL: begin
                    r_state <= S_EST_ADD;
                end

                S_EST_ADD: begin
                    r_est   <= r_est + w_eterm[EW-1:0];
                    r_state <= S_NEXT_I;
                end

                S_NEXT_I: begin
                    if (r_i == LAST_I) begin
                        r_state <= S_OUT;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_j     <= '0;
                        r_rank  <= '0;
                        r_state <= S_RANK;
                    end
                end

                // The result beat waits here until the output register is free.
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_occ       <= (r_est >= $signed(pos_pkg::HALF_Q24));
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[verif/periodic_occupancy_spectral_model_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for periodic_occupancy_spectral_model: directed table, then random
// add and query traffic over several register settings. Depends on pos_pkg and the block RTL.
module periodic_occupancy_spectral_model_tb;

    typedef longint unsigned t_u64;

    // Arctangent of 2^-k in turns (Q0.32), the same rotation angles the hardware uses.
    localparam logic [31:0] ATAN_TURN [0:23] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };
    localparam longint SAT_HI   = 64'sd140737488355327;
    localparam longint SAT_LO   = -64'sd140737488355328;
    localparam int     DRAIN_CY = 2500;   // covers the longest add, which returns no beat

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_req_type = pos_pkg::REQ_ADD;
    logic [31:0] i_time_s = '0;
    logic [15:0] i_probability = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_occupied;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = pos_pkg::CFG_ORDER;
    logic [15:0] i_cfg_data = '0;

    periodic_occupancy_spectral_model u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_time_s     (i_time_s),
        .i_probability(i_probability),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_occupied   (o_occupied),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the block's state and registers, advanced on every accepted input beat.
    logic [3:0]  order_reg;
    logic [15:0] thresh_reg;
    logic [31:0] mean_q24;
    logic [31:0] n_samples;
    longint      acc_re [pos_pkg::NUM_PERIODS];
    longint      acc_im [pos_pkg::NUM_PERIODS];

    bit occupancy_due_q[$];   // predicted occupancy answers, oldest first
    int fail_count = 0;
    bit calm = 1'b0;          // when set, neither side idles

    // Phase of time t, in turns, for period index i.
    function automatic logic [31:0] period_phase(input logic [31:0] t, input int i);
        t_u64 p;
        p = t_u64'(pos_pkg::NUM_PERIODS * 100 / (i + 1));
        if (p == 0) p = 1;
        return 32'((t_u64'(t % p) << 32) / p);
    endfunction

    // Rotation-mode CORDIC: gain-compensated cosine and sine (Q1.30) of angle z in turns.
    task automatic cordic_cos_sin(input logic [31:0] z, output longint c, output longint s);
        logic   flip;
        longint x, y, zz, nx, ny;
        flip = 1'b0;
        x = longint'(pos_pkg::GAIN_Q30);
        y = 0;
        // Fold the left half plane onto the right one and negate at the end.
        if (((z + 32'h4000_0000) & 32'h8000_0000) != 0) begin
            z = z ^ 32'h8000_0000;
            flip = 1'b1;
        end
        zz = longint'($signed(z));
        for (int k = 0; k < pos_pkg::STEPS; k++) begin
            if (zz >= 0) begin
                nx = x - (y >>> k); ny = y + (x >>> k); zz -= longint'(ATAN_TURN[k]);
            end else begin
                nx = x + (y >>> k); ny = y - (x >>> k); zz += longint'(ATAN_TURN[k]);
            end
            x = nx; y = ny;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Vectoring-mode CORDIC: unscaled magnitude and angle (turns) of one accumulator.
    task automatic cordic_mag_ang(input longint re, input longint im,
                                  output t_u64 mag, output logic [31:0] ang);
        longint      x, y, nx, ny;
        logic [31:0] z;
        x = re; y = im; z = '0;
        if (x < 0) begin
            x = -x; y = -y; z = 32'h8000_0000;
        end
        for (int k = 0; k < pos_pkg::STEPS; k++) begin
            if (y > 0) begin
                nx = x + (y >>> k); ny = y - (x >>> k); z += ATAN_TURN[k];
            end else begin
                nx = x - (y >>> k); ny = y + (x >>> k); z -= ATAN_TURN[k];
            end
            x = nx; y = ny;
        end
        mag = (x < 0) ? 0 : t_u64'(x);
        ang = z;
    endtask

    function automatic longint clip48(input longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    // Folds one measurement into the mean and the per-period accumulators.
    task automatic absorb_sample(input logic [31:0] t, input logic [15:0] prob);
        t_u64   n;
        longint p24, diff, c, s;
        n = t_u64'(n_samples);
        p24 = longint'(prob) << 8;
        mean_q24 = 32'((t_u64'(mean_q24) * n + t_u64'(p24) + (n + 1) / 2) / (n + 1));
        diff = p24 - longint'(mean_q24);
        for (int i = 0; i < pos_pkg::NUM_PERIODS; i++) begin
            cordic_cos_sin(period_phase(t, i), c, s);
            acc_re[i] = clip48(acc_re[i] + ((diff * c + (64'sd1 <<< 37)) >>> 38));
            acc_im[i] = clip48(acc_im[i] + ((diff * s + (64'sd1 <<< 37)) >>> 38));
        end
        if (n_samples != 32'hFFFF_FFFF) n_samples++;
    endtask

    // Predicted occupancy at time t from the strongest periodic components.
    task automatic predict_occupancy(input logic [31:0] t, output bit occ);
        t_u64        amp [pos_pkg::NUM_PERIODS];
        logic [31:0] ph [pos_pkg::NUM_PERIODS];
        t_u64        n, mag, a, q, r;
        longint      est, c, s;
        int          rank;
        n = t_u64'(n_samples);
        est = longint'(mean_q24);
        for (int i = 0; i < pos_pkg::NUM_PERIODS; i++) begin
            cordic_mag_ang(acc_re[i], acc_im[i], mag, ph[i]);
            a = 0;
            if (n != 0) begin
                q = mag / n;
                r = mag % n;
                if (q > (t_u64'(1) << 24)) q = t_u64'(1) << 24;
                a = (q * pos_pkg::GAIN_Q20 + (r * pos_pkg::GAIN_Q20) / n
                     + (t_u64'(1) << 19)) >> 20;
                if (a > pos_pkg::AMP_MAX) a = pos_pkg::AMP_MAX;
            end
            if (a < thresh_reg) a = 0;
            amp[i] = a;
        end
        for (int i = 0; i < pos_pkg::NUM_PERIODS; i++) begin
            rank = 0;
            // A lower index wins a tie in amplitude.
            for (int j = 0; j < pos_pkg::NUM_PERIODS; j++)
                if (amp[j] > amp[i] || (amp[j] == amp[i] && j < i)) rank++;
            if (rank < order_reg && amp[i] != 0) begin
                cordic_cos_sin(period_phase(t, i) - ph[i], c, s);
                est += (longint'(amp[i]) * c + (64'sd1 <<< 20)) >>> 21;
            end
        end
        occ = (est >= longint'(pos_pkg::HALF_Q24));
    endtask

    // Receiver: stall at random, except during the calm stretch.
    always @(posedge i_clk) begin
        i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 16);
    end

    // Output monitor: every accepted beat must match the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (occupancy_due_q.size() == 0) begin
                $error("occupied: unexpected beat, actual %0b", o_occupied);
                fail_count++;
            end else begin
                if (o_occupied !== occupancy_due_q[0]) begin
                    $error("occupied: expected %0b, actual %0b",
                           occupancy_due_q[0], o_occupied);
                    fail_count++;
                end
                void'(occupancy_due_q.pop_front());
            end
        end
    end

    // Offers one input beat, holds it until accepted, then updates the shadow state.
    // The caller is just past a rising edge; so is this task on return.
    task automatic send_beat(input logic req, input logic [31:0] t, input logic [15:0] prob,
                             input bit pinned, input bit pinned_occ);
        bit occ;
        int gap;
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_time_s      <= t;
        i_probability <= prob;
        do @(posedge i_clk); while (o_in_stall);
        if (req == pos_pkg::REQ_ADD) begin
            absorb_sample(t, prob);
        end else begin
            predict_occupancy(t, occ);
            if (pinned && occ != pinned_occ) begin
                $error("occupied: expected %0b, actual %0b (shadow state)", pinned_occ, occ);
                fail_count++;
            end
            occupancy_due_q = {occupancy_due_q, (pinned ? pinned_occ : occ)};
        end
        // Sender gap: valid goes low only when a gap is taken, never low and high in one step.
        if (!calm && $urandom_range(99) < 16) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Waits until every predicted beat has arrived and the last add has surely finished.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (occupancy_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CY) @(posedge i_clk);
    endtask

    // Drives one register write; the caller drops the write enable after the last one.
    task automatic write_reg(input logic idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == pos_pkg::CFG_ORDER) order_reg = val[3:0];
        else thresh_reg = val;
    endtask

    // Directed table: expected answer typed in only where it is obvious.
    typedef struct {
        logic        req;
        logic [31:0] t;
        logic [15:0] prob;
        bit          pinned;
        bit          occ;
    } t_stim_row;

    localparam int N_ROWS = 16;
    t_stim_row directed [N_ROWS] = '{
        '{pos_pkg::REQ_QUERY, 32'd0,          16'h0000, 1, 1},  // no samples: mean is half
        '{pos_pkg::REQ_QUERY, 32'hFFFF_FFFF,  16'hFFFF, 1, 1},  // probability ignored
        '{pos_pkg::REQ_ADD,   32'd0,          16'h0000, 0, 0},  // first sample: mean zero
        '{pos_pkg::REQ_QUERY, 32'd5,          16'h0000, 1, 0},  // zero accumulators
        '{pos_pkg::REQ_ADD,   32'hFFFF_FFFF,  16'hFFFF, 0, 0},
        '{pos_pkg::REQ_ADD,   32'd123,        16'h8000, 0, 0},
        '{pos_pkg::REQ_QUERY, 32'd400,        16'h0000, 0, 0},
        '{pos_pkg::REQ_ADD,   32'd200,        16'hFFFF, 0, 0},
        '{pos_pkg::REQ_ADD,   32'd600,        16'h0000, 0, 0},
        '{pos_pkg::REQ_ADD,   32'd1000,       16'hFFFF, 0, 0},
        '{pos_pkg::REQ_ADD,   32'd1400,       16'h0000, 0, 0},
        '{pos_pkg::REQ_QUERY, 32'd1800,       16'h0000, 0, 0},
        '{pos_pkg::REQ_QUERY, 32'd2200,       16'h0000, 0, 0},
        '{pos_pkg::REQ_QUERY, 32'h8000_0000,  16'h0000, 0, 0},
        '{pos_pkg::REQ_ADD,   32'h5555_5555,  16'hAAAA, 0, 0},
        '{pos_pkg::REQ_QUERY, 32'hAAAA_AAAA,  16'h5555, 0, 0}
    };

    // Register settings per random phase: extremes of order and threshold among them.
    localparam int N_PHASES = 6;
    int          phase_order  [N_PHASES] = '{0, 15, 8, 1, 4, 2};
    logic [15:0] phase_thresh [N_PHASES] = '{16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd3000, 16'd600};

    initial begin
        logic [31:0] now_s;
        logic [31:0] t;
        logic [15:0] prob;
        logic        req;
        order_reg  = 4'd2;
        thresh_reg = 16'd0;
        mean_q24   = 32'h0080_0000;
        n_samples  = '0;
        for (int i = 0; i < pos_pkg::NUM_PERIODS; i++) begin
            acc_re[i] = 0;
            acc_im[i] = 0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[r])
            send_beat(directed[r].req, directed[r].t, directed[r].prob,
                      directed[r].pinned, directed[r].occ);

        // Random phases. Each starts from an idle block, so the sender pauses until
        // every pending answer is back before the registers change.
        now_s = 32'd3000;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            write_reg(pos_pkg::CFG_ORDER, 16'(phase_order[ph]));
            write_reg(pos_pkg::CFG_THR,
                      (ph >= 4) ? 16'($urandom_range(0, 8000)) : phase_thresh[ph]);
            i_cfg_we <= 1'b0;
            calm = (ph == 3);
            for (int k = 0; k < 100; k++) begin
                // Mostly a day-like pattern over advancing time; some fully random beats.
                now_s += $urandom_range(1, 250);
                t = now_s;
                req = ($urandom_range(99) < 35) ? pos_pkg::REQ_QUERY : pos_pkg::REQ_ADD;
                if ($urandom_range(99) < 8) t = $urandom;
                case ($urandom_range(9))
                    0:       prob = 16'($urandom);
                    1:       prob = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    default: prob = ((t % 800) < 400) ? 16'($urandom_range(50000, 65535))
                                                      : 16'($urandom_range(0, 15000));
                endcase
                send_beat(req, t, prob, 0, 0);
            end
        end
        calm = 1'b0;
        wait_idle();

        if (fail_count == 0)
            $display("periodic_occupancy_spectral_model regression: pass");
        else
            $display("periodic_occupancy_spectral_model regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #200_000_000;
        $display("periodic_occupancy_spectral_model regression: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/core/pos_pkg.sv
rtl/core/periodic_occupancy_spectral_model.sv
verif/periodic_occupancy_spectral_model_tb.sv
